// ===== hdl/jet_pkg.sv =====
// shared types, register codes and saturation helper for the julia escape time pixel engine
package jet_pkg;

    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 12;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_REAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_IMAG   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd6;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 12'd255;

    typedef struct packed {
        logic capture;
        logic init_mul;
        logic init_add;
        logic iter_mul;
        logic iter_upd;
        logic mark_escape;
        logic load_out;
    } jet_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escape;
    } jet_status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [WORD_W-1:0] res;
        if (v[SUM_W-1:WORD_W-1] == '0 || v[SUM_W-1:WORD_W-1] == '1)
            res = v[WORD_W-1:0];
        else if (v[SUM_W-1])
            res = {1'b1, {(WORD_W-1){1'b0}}};
        else
            res = {1'b0, {(WORD_W-1){1'b1}}};
        return res;
    endfunction

endpackage

// ===== hdl/jet_ctrl.sv =====
// sequencing state machine for start point, iteration and result handoff
module jet_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  jet_pkg::jet_status_t status,
    output jet_pkg::jet_cmd_t    cmd
);
    import jet_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INIT_MUL = 3'd1;
    localparam logic [2:0] S_INIT_ADD = 3'd2;
    localparam logic [2:0] S_ITER_MUL = 3'd3;
    localparam logic [2:0] S_ITER_UPD = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_INIT_MUL;
                end
            end
            S_INIT_MUL:
            begin
                cmd.init_mul = 1'b1;
                state_next   = S_INIT_ADD;
            end
            S_INIT_ADD:
            begin
                cmd.init_add = 1'b1;
                state_next   = S_ITER_MUL;
            end
            S_ITER_MUL:
            begin
                if (status.at_limit)
                    state_next = S_FINISH;
                else
                begin
                    cmd.iter_mul = 1'b1;
                    state_next   = S_ITER_UPD;
                end
            end
            S_ITER_UPD:
            begin
                if (status.escape)
                begin
                    cmd.mark_escape = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = S_ITER_MUL;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/jet_datapath.sv =====
// fixed point datapath: start point, complex square, escape test and result register
module jet_datapath
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                                clk,
    input  jet_pkg::jet_cmd_t                   cmd,
    output jet_pkg::jet_status_t                status,
    input  logic [jet_pkg::COUNT_W-1:0]         column,
    input  logic [jet_pkg::COUNT_W-1:0]         row,
    input  logic signed [jet_pkg::WORD_W-1:0]   corner_real,
    input  logic signed [jet_pkg::WORD_W-1:0]   corner_imag,
    input  logic signed [jet_pkg::WORD_W-1:0]   step_real,
    input  logic signed [jet_pkg::WORD_W-1:0]   step_imag,
    input  logic signed [jet_pkg::WORD_W-1:0]   seed_real,
    input  logic signed [jet_pkg::WORD_W-1:0]   seed_imag,
    input  logic [jet_pkg::COUNT_W-1:0]         iteration_limit,
    output logic [jet_pkg::COUNT_W-1:0]         escape_count,
    output logic                                reached_limit
);
    import jet_pkg::*;

    localparam int ESC_BIT = 2 * FRAC_BITS + 2;

    logic [COUNT_W-1:0]        col_reg;
    logic [COUNT_W-1:0]        row_reg;
    logic signed [WORD_W-1:0]  zr_reg;
    logic signed [WORD_W-1:0]  zi_reg;
    logic signed [PROD_W-1:0]  pa_reg;
    logic signed [PROD_W-1:0]  pb_reg;
    logic signed [PROD_W-1:0]  pc_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      escaped_reg;
    logic [COUNT_W-1:0]        escape_count_reg;
    logic                      reached_limit_reg;

    logic signed [WORD_W-1:0]  ma;
    logic signed [WORD_W-1:0]  mb;
    logic signed [WORD_W-1:0]  na;
    logic signed [WORD_W-1:0]  nb;
    logic signed [PROD_W-1:0]  pa_next;
    logic signed [PROD_W-1:0]  pb_next;
    logic signed [PROD_W-1:0]  pc_next;
    logic signed [SUM_W-1:0]   start_re;
    logic signed [SUM_W-1:0]   start_im;
    logic [PROD_W-1:0]         mag;
    logic signed [SUM_W-1:0]   diff;
    logic signed [SUM_W-1:0]   new_re;
    logic signed [SUM_W-1:0]   new_im;

    // operand select: pixel offset products at start, square terms while iterating
    always_comb
    begin
        if (cmd.init_mul)
        begin
            ma = $signed({{(WORD_W-COUNT_W){1'b0}}, col_reg});
            mb = step_real;
            na = $signed({{(WORD_W-COUNT_W){1'b0}}, row_reg});
            nb = step_imag;
        end
        else
        begin
            ma = zr_reg;
            mb = zr_reg;
            na = zi_reg;
            nb = zi_reg;
        end
    end

    assign pa_next = PROD_W'(ma) * PROD_W'(mb);
    assign pb_next = PROD_W'(na) * PROD_W'(nb);
    assign pc_next = PROD_W'(zr_reg) * PROD_W'(zi_reg);

    assign start_re = SUM_W'(corner_real) + SUM_W'(pa_reg);
    assign start_im = SUM_W'(corner_imag) - SUM_W'(pb_reg);

    assign mag    = pa_reg + pb_reg;
    assign diff   = SUM_W'(pa_reg) - SUM_W'(pb_reg);
    assign new_re = SUM_W'(seed_real) + (diff >>> FRAC_BITS);
    assign new_im = SUM_W'(seed_imag) + (SUM_W'(pc_reg) >>> (FRAC_BITS - 1));

    assign status.escape   = ((mag >> ESC_BIT) != '0);
    assign status.at_limit = (count_reg >= iteration_limit);

    assign escape_count  = escape_count_reg;
    assign reached_limit = reached_limit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.init_mul || cmd.iter_mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (cmd.init_add)
        begin
            zr_reg      <= sat_word(start_re);
            zi_reg      <= sat_word(start_im);
            count_reg   <= '0;
            escaped_reg <= 1'b0;
        end
        if (cmd.iter_upd)
        begin
            zr_reg    <= sat_word(new_re);
            zi_reg    <= sat_word(new_im);
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (cmd.mark_escape)
            escaped_reg <= 1'b1;
        if (cmd.load_out)
        begin
            escape_count_reg  <= count_reg;
            reached_limit_reg <= !escaped_reg;
        end
    end

endmodule

// ===== hdl/julia_escape_time_pixel.sv =====
// julia escape time pixel engine: register bank, controller and datapath
// the iteration loop alternates the complex square (three 32x32 multiplies) with the escape
// test and update, and ends when the iteration limit n is reached or the point escapes; one
// item at a time: a new item is accepted only after the previous one has been handed off,
// which waits while the previous result is still stalled
// reset: configuration clears to zero with iteration_limit 255, controller idle, no result
module julia_escape_time_pixel
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [jet_pkg::COUNT_W-1:0]         column,
    input  logic [jet_pkg::COUNT_W-1:0]         row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [jet_pkg::COUNT_W-1:0]         escape_count,
    output logic                                reached_limit,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jet_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jet_pkg::WORD_W-1:0]          cfg_data
);
    import jet_pkg::*;

    logic signed [WORD_W-1:0] corner_real_reg;
    logic signed [WORD_W-1:0] corner_imag_reg;
    logic signed [WORD_W-1:0] step_real_reg;
    logic signed [WORD_W-1:0] step_imag_reg;
    logic signed [WORD_W-1:0] seed_real_reg;
    logic signed [WORD_W-1:0] seed_imag_reg;
    logic [COUNT_W-1:0]       iteration_limit_reg;

    jet_cmd_t    cmd;
    jet_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_real_reg     <= '0;
            corner_imag_reg     <= '0;
            step_real_reg       <= '0;
            step_imag_reg       <= '0;
            seed_real_reg       <= '0;
            seed_imag_reg       <= '0;
            iteration_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CORNER_REAL: corner_real_reg     <= $signed(cfg_data);
                REG_CORNER_IMAG: corner_imag_reg     <= $signed(cfg_data);
                REG_STEP_REAL:   step_real_reg       <= $signed(cfg_data);
                REG_STEP_IMAG:   step_imag_reg       <= $signed(cfg_data);
                REG_SEED_REAL:   seed_real_reg       <= $signed(cfg_data);
                REG_SEED_IMAG:   seed_imag_reg       <= $signed(cfg_data);
                REG_ITER_LIMIT:  iteration_limit_reg <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    jet_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    jet_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .cmd             (cmd),
        .status          (status),
        .column          (column),
        .row             (row),
        .corner_real     (corner_real_reg),
        .corner_imag     (corner_imag_reg),
        .step_real       (step_real_reg),
        .step_imag       (step_imag_reg),
        .seed_real       (seed_real_reg),
        .seed_imag       (seed_imag_reg),
        .iteration_limit (iteration_limit_reg),
        .escape_count    (escape_count),
        .reached_limit   (reached_limit)
    );

endmodule
